[rtl/ffe_pkg.sv]
package ffe_pkg;

  localparam int NPOS_W  = 4;
  localparam int SLOTS   = 3;
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = 2;
  localparam int Q_CNT_W = 3;

  localparam logic [NPOS_W-1:0] NAME_BYTES = 4'd8;

  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_END  = 1'b1;

  localparam logic [7:0] CH_PCT    = 8'h25;
  localparam logic [7:0] CH_AMP    = 8'h26;
  localparam logic [7:0] CH_EQ     = 8'h3d;
  localparam logic [7:0] CH_PLUS   = 8'h2b;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CASE_MASK = 8'hdf;

  typedef enum logic [1:0] {
    REG_MATCH_NAME   = 2'd0,
    REG_MATCH_LENGTH = 2'd1,
    REG_SELECT_INDEX = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic [63:0] match_name;
    logic [3:0]  match_length;
    logic [15:0] select_index;
  } cfg_t;

  // One accepted request worth of results: up to three data bytes in slot
  // order, then an optional done result.
  typedef struct packed {
    logic [SLOTS-1:0][7:0] byt;
    logic [SLOTS-1:0]      msk;
    logic                  done;
    logic                  found;
  } rec_t;

endpackage

[rtl/form_field_extractor.sv]
// A request's results pass through the request queue, the sequencer's current-record register and
// the registered out_ port. Throughput: one request per cycle while in_stall is low; the result port
// delivers one result per cycle while out_stall is low, and a request yields at most three results.
// A four-entry request queue between the decoder and the output sequencer absorbs bursts.
// Reset (rst_n low, synchronous) clears the decoder state, the queue and the output valid;
// configuration registers reset to zero.
module form_field_extractor
  import ffe_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_op,
  input  logic [7:0]  in_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic        out_byte_valid,
  output logic        out_done_res,
  output logic        out_found,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  cfg_t cfg_r;
  logic accept, push, pop, q_valid, q_full;
  rec_t wr_rec, rd_rec;

  assign cfg_ready = 1'b1;
  assign in_stall  = q_full;
  assign accept    = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (reg_idx_t'(cfg_index))
        REG_MATCH_NAME:   cfg_r.match_name   <= cfg_data;
        REG_MATCH_LENGTH: cfg_r.match_length <= cfg_data[3:0];
        REG_SELECT_INDEX: cfg_r.select_index <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  ffe_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .accept  (accept),
    .in_op   (in_op),
    .in_byte (in_byte),
    .push    (push),
    .rec     (wr_rec)
  );

  ffe_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .wr_rec  (wr_rec),
    .pop     (pop),
    .q_valid (q_valid),
    .q_full  (q_full),
    .rd_rec  (rd_rec)
  );

  ffe_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_valid        (q_valid),
    .q_rec          (rd_rec),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_byte       (out_byte),
    .out_byte_valid (out_byte_valid),
    .out_done_res   (out_done_res),
    .out_found      (out_found)
  );

endmodule

[rtl/ffe_front.sv]
module ffe_front
  import ffe_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  cfg_t   cfg,
  input  logic   accept,
  input  logic   in_op,
  input  logic [7:0] in_byte,
  output logic   push,
  output rec_t   rec
);

  typedef struct packed {
    logic [1:0]        esc;
    logic [7:0]        held;
    logic [15:0]       pcnt;
    logic [NPOS_W-1:0] npos;
    logic              nmatch;
    logic              inval;
    logic              emit;
    logic              fin;
  } st_t;

  typedef struct packed {
    st_t  st;
    logic out;
  } dres_t;

  localparam logic [7:0] CH_LA = 8'h61;
  localparam logic [7:0] CH_LZ = 8'h7a;

  function automatic logic is_hex(input logic [7:0] b);
    return (b >= 8'h30 && b <= 8'h39) || (b >= 8'h61 && b <= 8'h66) ||
           (b >= 8'h41 && b <= 8'h46);
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] b);
    logic [7:0] d;
    d = 8'h00;
    if (b >= 8'h30 && b <= 8'h39) d = b - 8'h30;
    else if (b >= 8'h61 && b <= 8'h66) d = b - 8'h57;
    else if (b >= 8'h41 && b <= 8'h46) d = b - 8'h37;
    return d[3:0];
  endfunction

  function automatic dres_t dec_char(input st_t s, input logic [7:0] c, input cfg_t cf,
                                     input logic [NPOS_W-1:0] ulen);
    dres_t      r;
    logic [7:0] m;
    logic [7:0] low;
    logic       same;
    r.st  = s;
    r.out = 1'b0;
    m     = cf.match_name[{s.npos[2:0], 3'b000} +: 8];
    low   = c | 8'h20;
    if (low >= CH_LA && low <= CH_LZ) same = ((c ^ m) & CASE_MASK) == 8'h00;
    else same = (c == m);
    if (cf.select_index != 16'd0 || s.inval) begin
      r.out = s.emit;
    end else if (s.nmatch && s.npos < ulen) begin
      if (same) r.st.npos = s.npos + 4'd1;
      else r.st.nmatch = 1'b0;
    end else begin
      r.st.nmatch = 1'b0;
    end
    return r;
  endfunction

  function automatic dres_t raw_byte(input st_t s, input logic [7:0] b, input cfg_t cf,
                                     input logic [NPOS_W-1:0] ulen);
    dres_t r;
    r.st  = s;
    r.out = 1'b0;
    if (b == CH_PCT) begin
      r.st.esc = 2'd1;
    end else if (b == CH_AMP) begin
      if (s.emit) begin
        r.st.emit = 1'b0;
        r.st.fin  = 1'b1;
      end
      if (s.pcnt != 16'hffff) r.st.pcnt = s.pcnt + 16'd1;
      r.st.npos   = '0;
      r.st.nmatch = 1'b1;
      r.st.inval  = 1'b0;
    end else if (b == CH_EQ) begin
      if (cf.select_index == 16'd0 && !s.inval) begin
        r.st.inval = 1'b1;
        if (s.nmatch && s.npos == ulen) r.st.emit = 1'b1;
      end else begin
        r.out = s.emit;
      end
    end else if (b == CH_PLUS) begin
      r = dec_char(s, CH_SPACE, cf, ulen);
    end else begin
      r = dec_char(s, b, cf, ulen);
    end
    return r;
  endfunction

  st_t st_r, st_nxt;

  always_comb begin
    logic [NPOS_W-1:0] ulen;
    st_t   s0, s1, s2, s3;
    dres_t da, db, dc;
    logic  hexb, esc1, esc2;
    logic  a_en, b_en, c_en;
    logic [7:0] a_ch, hv;
    logic [3:0] hi;

    ulen   = (cfg.match_length > NAME_BYTES) ? NAME_BYTES : cfg.match_length;
    st_nxt = st_r;
    rec    = '0;
    push   = 1'b0;
    s0     = st_r;
    hexb   = is_hex(in_byte);
    esc1   = (st_r.esc == 2'd1);
    esc2   = (st_r.esc == 2'd2);
    hi     = is_hex(st_r.held) ? hex_val(st_r.held) : 4'd0;
    hv     = {hi, hex_val(in_byte)};
    if (hv == 8'h00) hv = CH_SPACE;

    if (in_op == OP_END) begin
      a_en = !st_r.fin && (esc1 || esc2);
      a_ch = CH_PCT;
      b_en = !st_r.fin && esc2;
      c_en = 1'b0;
    end else begin
      if (cfg.select_index != 16'd0 && !s0.emit &&
          ({1'b0, s0.pcnt} + 17'd1) == {1'b0, cfg.select_index}) begin
        s0.emit = 1'b1;
      end
      a_en = (esc1 && !hexb) || esc2;
      a_ch = (esc2 && hexb) ? hv : CH_PCT;
      b_en = esc2 && !hexb;
      c_en = !((esc1 || esc2) && hexb);
      // The escape state is settled before the raw byte, which may open a new one.
      if (esc1 && hexb) begin
        s0.held = in_byte;
        s0.esc  = 2'd2;
      end else begin
        s0.esc = 2'd0;
      end
    end

    da = dec_char(s0, a_ch, cfg, ulen);
    s1 = a_en ? da.st : s0;
    db = dec_char(s1, st_r.held, cfg, ulen);
    s2 = b_en ? db.st : s1;
    dc = raw_byte(s2, in_byte, cfg, ulen);
    s3 = c_en ? dc.st : s2;

    rec.byt[0] = a_ch;
    rec.byt[1] = st_r.held;
    rec.byt[2] = (in_byte == CH_PLUS) ? CH_SPACE : in_byte;
    rec.msk    = {c_en & dc.out, b_en & db.out, a_en & da.out};

    if (in_op == OP_END) begin
      rec.msk[2] = 1'b0;
      rec.done   = 1'b1;
      rec.found  = s2.fin || s2.emit;
      push       = accept;
      if (accept) begin
        st_nxt        = '0;
        st_nxt.nmatch = 1'b1;
      end
    end else if (!st_r.fin) begin
      push = accept && (|rec.msk);
      if (accept) st_nxt = s3;
    end else begin
      rec.msk = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= '0;
      st_r.nmatch <= 1'b1;
    end else begin
      st_r <= st_nxt;
    end
  end

endmodule

[rtl/ffe_queue.sv]
module ffe_queue
  import ffe_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  rec_t wr_rec,
  input  logic pop,
  output logic q_valid,
  output logic q_full,
  output rec_t rd_rec
);

  rec_t               mem [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [Q_CNT_W-1:0] count_r, count_nxt;
  logic               do_push, do_pop;

  assign q_valid = (count_r != '0);
  assign q_full  = (count_r == Q_CNT_W'(Q_DEPTH));
  assign rd_rec  = mem[rd_ptr_r];
  assign do_push = push && !q_full;
  assign do_pop  = pop && q_valid;

  always_comb begin
    count_nxt = count_r;
    if (do_push && !do_pop) count_nxt = count_r + Q_CNT_W'(1);
    else if (do_pop && !do_push) count_nxt = count_r - Q_CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr_r] <= wr_rec;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + Q_PTR_W'(1);
      if (do_pop) rd_ptr_r <= rd_ptr_r + Q_PTR_W'(1);
      count_r <= count_nxt;
    end
  end

endmodule

[rtl/ffe_back.sv]
module ffe_back
  import ffe_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       q_valid,
  input  rec_t       q_rec,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       out_byte_valid,
  output logic       out_done_res,
  output logic       out_found
);

  rec_t       cur_r, cur_nxt;
  logic       cur_v_r, cur_v_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic [7:0] obyte_r, obyte_nxt;
  logic       obv_r, obv_nxt, odone_r, odone_nxt, ofound_r, ofound_nxt;
  logic       out_free, go, has_data, last;
  logic [SLOTS-1:0] pick, msk_left;

  assign out_free = !out_valid_r || !out_stall;
  assign go       = out_free && cur_v_r;
  assign has_data = |cur_r.msk;

  always_comb begin
    pick = '0;
    priority if (cur_r.msk[0]) pick[0] = 1'b1;
    else if (cur_r.msk[1]) pick[1] = 1'b1;
    else if (cur_r.msk[2]) pick[2] = 1'b1;
    msk_left = cur_r.msk & ~pick;
  end

  always_comb begin
    last = go && (has_data ? (msk_left == '0 && !cur_r.done) : 1'b1);
    pop  = q_valid && (!cur_v_r || last);

    cur_nxt = cur_r;
    if (go) begin
      if (has_data) cur_nxt.msk = msk_left;
      else cur_nxt.done = 1'b0;
    end
    if (pop) cur_nxt = q_rec;
    cur_v_nxt = pop ? 1'b1 : (last ? 1'b0 : cur_v_r);

    out_valid_nxt = out_free ? go : out_valid_r;
    obyte_nxt     = obyte_r;
    obv_nxt       = obv_r;
    odone_nxt     = odone_r;
    ofound_nxt    = ofound_r;
    if (go) begin
      if (has_data) begin
        obyte_nxt  = pick[0] ? cur_r.byt[0] : (pick[1] ? cur_r.byt[1] : cur_r.byt[2]);
        obv_nxt    = 1'b1;
        odone_nxt  = 1'b0;
        ofound_nxt = 1'b0;
      end else begin
        obyte_nxt  = 8'h00;
        obv_nxt    = 1'b0;
        odone_nxt  = 1'b1;
        ofound_nxt = cur_r.found;
      end
    end
  end

  always_ff @(posedge clk) begin
    cur_r    <= cur_nxt;
    obyte_r  <= obyte_nxt;
    obv_r    <= obv_nxt;
    odone_r  <= odone_nxt;
    ofound_r <= ofound_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_v_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cur_v_r     <= cur_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_byte       = obyte_r;
  assign out_byte_valid = obv_r;
  assign out_done_res   = odone_r;
  assign out_found      = ofound_r;

endmodule

[rtl/ffe_checker.sv]
module ffe_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic [7:0]  out_byte,
  input logic        out_byte_valid,
  input logic        out_done_res,
  input logic        out_found
);

  // A result is either a data byte or the done report, never both or neither.
  a_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_byte_valid != out_done_res))
    else $error("result is neither a plain byte nor a done report");

  // Found is only reported with done, and the done result carries a zero byte.
  a_found: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_done_res) |-> !out_found)
    else $error("found raised on a data result");

  a_done_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_done_res) |-> (out_byte == 8'h00))
    else $error("done result carries a nonzero byte");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_byte) &&
                                  $stable(out_done_res) && $stable(out_found)))
    else $error("stalled result changed");

  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind form_field_extractor ffe_checker u_ffe_checker (.*);

[verif/form_field_extractor_tb.sv]
`timescale 1ns / 100ps

module form_field_extractor_tb;
  import ffe_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int HOLD_CYCLES  = 60;
  localparam int DRAIN_CYCLES = 6;
  localparam int PHASES       = 8;
  localparam int PHASE_ITEMS  = 8;
  localparam int BURST_BYTES  = 10;

  typedef struct packed {
    logic [7:0] dbyte;
    logic       bval;
    logic       dn;
    logic       fnd;
  } result_t;

  typedef struct packed {
    logic       op;
    logic [7:0] data;
  } req_t;

  typedef struct packed {
    bit          is_cfg;
    logic [63:0] nm;
    logic [3:0]  ln;
    logic [15:0] sel;
    logic        op;
    logic [7:0]  data;
    bit          typed;
    bit          has_res;
    result_t     res;
  } row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_op = OP_BYTE;
  logic [7:0]  in_byte = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_byte;
  logic        out_byte_valid;
  logic        out_done_res;
  logic        out_found;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = REG_MATCH_NAME;
  logic [63:0] cfg_data = 64'd0;

  form_field_extractor dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_op          (in_op),
    .in_byte        (in_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_byte       (out_byte),
    .out_byte_valid (out_byte_valid),
    .out_done_res   (out_done_res),
    .out_found      (out_found),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Decoder copy: configuration and per-string state.
  logic [63:0] cfg_name = 64'd0;
  logic [3:0]  cfg_len = 4'd0;
  logic [15:0] sel_index = 16'd0;

  logic [1:0]  esc_phase = 2'd0;
  logic [7:0]  held_hex = 8'd0;
  logic [15:0] pairs_seen = 16'd0;
  logic [3:0]  name_pos = 4'd0;
  logic        name_ok = 1'b1;
  logic        in_value = 1'b0;
  logic        emitting = 1'b0;
  logic        field_closed = 1'b0;

  result_t decoded_q[$];
  req_t    text_q[$];
  row_t    plan[$];

  bit idle_on = 1'b1;
  bit hold_ask = 1'b0;
  int fail_count = 0;
  int requests_sent = 0;
  int strings_ended = 0;
  int results_checked = 0;
  int found_count = 0;
  int cfg_writes = 0;
  int cycle_count = 0;

  function automatic result_t mk_res(logic [7:0] b, logic v, logic d, logic f);
    result_t r;
    r.dbyte = b;
    r.bval = v;
    r.dn = d;
    r.fnd = f;
    return r;
  endfunction

  function automatic void put_result(logic [7:0] b, logic v, logic d, logic f);
    decoded_q.push_back(mk_res(b, v, d, f));
  endfunction

  function automatic logic [3:0] name_span();
    return (cfg_len > NAME_BYTES) ? NAME_BYTES : cfg_len;
  endfunction

  function automatic int hex_val(logic [7:0] b);
    if (b >= "0" && b <= "9") return b - "0";
    if (b >= "a" && b <= "f") return b - "a" + 10;
    if (b >= "A" && b <= "F") return b - "A" + 10;
    return -1;
  endfunction

  // A decoded character either feeds the name comparison or, inside the
  // selected field, goes straight out.
  function automatic void take_decoded(logic [7:0] c);
    logic [7:0] m;
    logic [7:0] low;
    logic       same;
    if (sel_index != 16'd0 || in_value) begin
      if (emitting) put_result(c, 1'b1, 1'b0, 1'b0);
      return;
    end
    if (name_ok && name_pos < name_span()) begin
      m = cfg_name[8*name_pos[2:0] +: 8];
      low = c | 8'h20;
      if (low >= "a" && low <= "z") begin
        same = ((c ^ m) & CASE_MASK) == 8'h00;
      end else begin
        same = (c == m);
      end
      if (same) begin
        name_pos++;
      end else begin
        name_ok = 1'b0;
      end
    end else begin
      name_ok = 1'b0;
    end
  endfunction

  function automatic void take_raw(logic [7:0] b);
    if (b == CH_PCT) begin
      esc_phase = 2'd1;
    end else if (b == CH_AMP) begin
      if (emitting) begin
        emitting = 1'b0;
        field_closed = 1'b1;
      end
      if (pairs_seen != 16'hffff) pairs_seen++;
      name_pos = 4'd0;
      name_ok = 1'b1;
      in_value = 1'b0;
    end else if (b == CH_EQ) begin
      if (sel_index == 16'd0 && !in_value) begin
        in_value = 1'b1;
        if (name_ok && name_pos == name_span()) emitting = 1'b1;
      end else if (emitting) begin
        put_result(b, 1'b1, 1'b0, 1'b0);
      end
    end else if (b == CH_PLUS) begin
      take_decoded(CH_SPACE);
    end else begin
      take_decoded(b);
    end
  endfunction

  function automatic void decode_request(logic op, logic [7:0] b);
    int lo;
    logic [7:0] v;
    if (op == OP_END) begin
      if (!field_closed) begin
        if (esc_phase == 2'd1) begin
          take_decoded(CH_PCT);
        end else if (esc_phase == 2'd2) begin
          take_decoded(CH_PCT);
          take_decoded(held_hex);
        end
      end
      put_result(8'h00, 1'b0, 1'b1, field_closed || emitting);
      esc_phase = 2'd0;
      held_hex = 8'd0;
      pairs_seen = 16'd0;
      name_pos = 4'd0;
      name_ok = 1'b1;
      in_value = 1'b0;
      emitting = 1'b0;
      field_closed = 1'b0;
      return;
    end
    if (field_closed) return;
    if (sel_index != 16'd0 && !emitting && int'(pairs_seen) + 1 == int'(sel_index))
      emitting = 1'b1;
    if (esc_phase == 2'd1) begin
      if (hex_val(b) >= 0) begin
        held_hex = b;
        esc_phase = 2'd2;
      end else begin
        esc_phase = 2'd0;
        take_decoded(CH_PCT);
        take_raw(b);
      end
    end else if (esc_phase == 2'd2) begin
      lo = hex_val(b);
      esc_phase = 2'd0;
      if (lo >= 0) begin
        v = 8'(hex_val(held_hex) * 16 + lo);
        // An escaped NUL comes out as a space.
        if (v == 8'h00) v = CH_SPACE;
        take_decoded(v);
      end else begin
        take_decoded(CH_PCT);
        take_decoded(held_hex);
        take_raw(b);
      end
    end else begin
      esc_phase = 2'd0;
      take_raw(b);
    end
  endfunction

  function automatic void queue_req(logic op, logic [7:0] b);
    req_t r;
    r.op = op;
    r.data = b;
    text_q.push_back(r);
  endfunction

  function automatic logic [7:0] hex_char(logic [3:0] n);
    if (n < 4'd10) return 8'h30 + n;
    return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + n - 8'd10;
  endfunction

  function automatic logic [7:0] name_char();
    logic [7:0] c;
    if ($urandom_range(0, 3) == 0) return 8'($urandom_range(0, 255));
    c = 8'h61 + 8'($urandom_range(0, 25));
    return $urandom_range(0, 1) ? (c ^ 8'h20) : c;
  endfunction

  function automatic logic [63:0] random_name();
    logic [63:0] nm;
    for (int i = 0; i < 8; i++) nm[8*i +: 8] = name_char();
    return nm;
  endfunction

  // Puts one name byte on the wire so that it decodes back to itself, up to the case of a letter.
  function automatic void push_encoded(logic [7:0] b);
    logic [7:0] low;
    low = b | 8'h20;
    if (b == CH_PCT || b == CH_AMP || b == CH_EQ || b == CH_PLUS ||
        (b != 8'h00 && $urandom_range(0, 3) == 0)) begin
      queue_req(OP_BYTE, CH_PCT);
      queue_req(OP_BYTE, hex_char(b[7:4]));
      queue_req(OP_BYTE, hex_char(b[3:0]));
    end else if (b == CH_SPACE && $urandom_range(0, 1)) begin
      queue_req(OP_BYTE, CH_PLUS);
    end else if (low >= "a" && low <= "z" && $urandom_range(0, 1)) begin
      queue_req(OP_BYTE, b ^ 8'h20);
    end else begin
      queue_req(OP_BYTE, b);
    end
  endfunction

  function automatic void push_value_piece();
    case ($urandom_range(0, 6))
      0: queue_req(OP_BYTE, 8'($urandom_range(0, 255)));
      1, 2: queue_req(OP_BYTE, name_char());
      3: queue_req(OP_BYTE, CH_PLUS);
      4: begin
        queue_req(OP_BYTE, CH_PCT);
        queue_req(OP_BYTE, hex_char(4'($urandom_range(0, 15))));
        queue_req(OP_BYTE, hex_char(4'($urandom_range(0, 15))));
      end
      5: begin
        queue_req(OP_BYTE, CH_PCT);
        queue_req(OP_BYTE, hex_char(4'($urandom_range(0, 15))));
        queue_req(OP_BYTE, 8'($urandom_range(0, 255)));
      end
      default: begin
        queue_req(OP_BYTE, CH_PCT);
        queue_req(OP_BYTE, 8'($urandom_range(0, 255)));
      end
    endcase
  endfunction

  // Mostly well-formed strings whose names often hit the configured one,
  // with some pure noise strings mixed in.
  function automatic void build_string();
    int npairs;
    int span;
    bit shorten;
    span = name_span();
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 10)) queue_req(OP_BYTE, 8'($urandom_range(0, 255)));
    end else begin
      npairs = $urandom_range(1, 3);
      for (int p = 0; p < npairs; p++) begin
        if (p > 0) queue_req(OP_BYTE, CH_AMP);
        if (sel_index == 16'd0 && $urandom_range(0, 1)) begin
          shorten = ($urandom_range(0, 4) == 0);
          for (int i = 0; i < span; i++) begin
            if (!(shorten && i == span - 1)) push_encoded(cfg_name[8*i +: 8]);
          end
          if ($urandom_range(0, 4) == 0) push_encoded(name_char());
        end else begin
          repeat ($urandom_range(0, 3)) push_encoded(name_char());
        end
        if ($urandom_range(0, 7) != 0) begin
          queue_req(OP_BYTE, CH_EQ);
          repeat ($urandom_range(0, 4)) push_value_piece();
        end
      end
      if ($urandom_range(0, 5) == 0) queue_req(OP_BYTE, CH_AMP);
    end
    queue_req(OP_END, 8'h00);
  endfunction

  function automatic void plan_cfg(logic [63:0] nm, logic [3:0] ln, logic [15:0] sel);
    row_t r;
    r = '0;
    r.is_cfg = 1'b1;
    r.nm = nm;
    r.ln = ln;
    r.sel = sel;
    plan.push_back(r);
  endfunction

  function automatic void plan_item(logic op, logic [7:0] b);
    row_t r;
    r = '0;
    r.op = op;
    r.data = b;
    plan.push_back(r);
  endfunction

  function automatic void plan_typed(logic op, logic [7:0] b, bit has_res, result_t res);
    row_t r;
    r = '0;
    r.op = op;
    r.data = b;
    r.typed = 1'b1;
    r.has_res = has_res;
    r.res = res;
    plan.push_back(r);
  endfunction

  // Called at a rising edge; returns at the edge where the request is taken.
  task automatic push_request(logic op, logic [7:0] b, bit typed, bit has_res,
                              result_t res);
    int q_mark;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_op <= op;
    in_byte <= b;
    do @(posedge clk); while (in_stall);
    q_mark = decoded_q.size();
    decode_request(op, b);
    if (typed) begin
      while (decoded_q.size() > q_mark) void'(decoded_q.pop_back());
      if (has_res) decoded_q.push_back(res);
    end
    requests_sent++;
    if (op == OP_END) strings_ended++;
  endtask

  // A byte can leave no result behind, so allow the pipeline to drain too.
  task automatic settle();
    in_valid <= 1'b0;
    while (decoded_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic configure(logic [63:0] nm, logic [3:0] ln, logic [15:0] sel);
    reg_idx_t order [3];
    order = '{REG_MATCH_NAME, REG_MATCH_LENGTH, REG_SELECT_INDEX};
    foreach (order[i]) begin
      cfg_valid <= 1'b1;
      cfg_index <= order[i];
      case (order[i])
        REG_MATCH_NAME:   cfg_data <= nm;
        REG_MATCH_LENGTH: cfg_data <= 64'(ln);
        default:          cfg_data <= 64'(sel);
      endcase
      do @(posedge clk); while (!cfg_ready);
      cfg_writes++;
    end
    cfg_valid <= 1'b0;
    cfg_name = nm;
    cfg_len = ln;
    sel_index = sel;
  endtask

  task automatic check_field(string what, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %02h, got %02h", $time, what, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (decoded_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, got %02h/%0b/%0b/%0b",
                 $time, out_byte, out_byte_valid, out_done_res, out_found);
        fail_count++;
      end else begin
        want = decoded_q.pop_front();
        check_field("out_byte", want.dbyte, out_byte);
        check_field("out_byte_valid", 8'(want.bval), 8'(out_byte_valid));
        check_field("out_done_res", 8'(want.dn), 8'(out_done_res));
        check_field("out_found", 8'(want.fnd), 8'(out_found));
        results_checked++;
        if (want.dn && want.fnd) found_count++;
      end
    end
  end

  // Result side: short random stalls, plus one long hold when asked for.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_ask) begin
        hold_ask = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 6)) @(posedge clk);
        out_stall <= 1'b0;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d results still outstanding", $time, decoded_q.size());
      $display("simulation failed");
      $finish;
    end
  end

  initial begin : stimulus
    logic [63:0] nm;
    logic [3:0]  ln;
    logic [15:0] sel;
    int          placed;
    req_t        r;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings select by name with an empty name, so a pair whose
    // name is empty matches right away.
    plan_typed(OP_BYTE, CH_EQ, 1'b0, '0);
    plan_typed(OP_BYTE, 8'hff, 1'b1, mk_res(8'hff, 1'b1, 1'b0, 1'b0));
    plan_typed(OP_BYTE, 8'h00, 1'b1, mk_res(8'h00, 1'b1, 1'b0, 1'b0));
    plan_typed(OP_BYTE, CH_PCT, 1'b0, '0);
    plan_typed(OP_BYTE, "0", 1'b0, '0);
    plan_typed(OP_BYTE, "0", 1'b1, mk_res(CH_SPACE, 1'b1, 1'b0, 1'b0));
    plan_typed(OP_BYTE, CH_AMP, 1'b0, '0);
    plan_typed(OP_BYTE, "z", 1'b0, '0);
    plan_typed(OP_END, 8'h00, 1'b1, mk_res(8'h00, 1'b0, 1'b1, 1'b1));

    // Name "Ab" spelled with mixed case and an escape; an escaped '=' in the
    // value is data, and a half escape is flushed by the end.
    plan_cfg(64'h6241, 4'd2, 16'd0);
    plan_item(OP_BYTE, "a");
    plan_item(OP_BYTE, CH_PCT);
    plan_item(OP_BYTE, "4");
    plan_item(OP_BYTE, "2");
    plan_item(OP_BYTE, CH_EQ);
    plan_item(OP_BYTE, CH_PCT);
    plan_item(OP_BYTE, "3");
    plan_item(OP_BYTE, "D");
    plan_item(OP_BYTE, CH_PLUS);
    plan_item(OP_BYTE, CH_PCT);
    plan_item(OP_BYTE, "7");
    plan_item(OP_END, 8'h00);

    // Switch to index mode in the middle of a string.
    plan_item(OP_BYTE, "q");
    plan_item(OP_BYTE, CH_AMP);
    plan_cfg(64'h6241, 4'd2, 16'd2);
    plan_item(OP_BYTE, "y");
    plan_item(OP_BYTE, CH_EQ);
    plan_item(OP_BYTE, "z");
    plan_item(OP_END, 8'h00);

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        settle();
        configure(plan[i].nm, plan[i].ln, plan[i].sel);
      end else begin
        push_request(plan[i].op, plan[i].data, plan[i].typed, plan[i].has_res,
                     plan[i].res);
      end
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      settle();
      // Phase 4 runs the long output hold; the last phase runs flat out.
      idle_on = !(ph == 4 || ph == PHASES - 1);
      case (ph)
        0: begin nm = random_name(); ln = 4'd8; sel = 16'd0; end
        1: begin nm = '1; ln = 4'd15; sel = 16'd0; end
        2: begin nm = random_name(); ln = 4'($urandom_range(1, 8)); sel = 16'd1; end
        3: begin nm = random_name(); ln = 4'd3; sel = 16'hffff; end
        4: begin nm = random_name(); ln = 4'd1; sel = 16'd1; end
        5: begin nm = random_name(); ln = 4'd2; sel = 16'($urandom_range(2, 4)); end
        6: begin nm = '0; ln = 4'd0; sel = 16'd0; end
        default: begin nm = random_name(); ln = 4'($urandom_range(1, 8)); sel = 16'd0; end
      endcase
      configure(nm, ln, sel);
      if (ph == 4) begin
        hold_ask = 1'b1;
        // The first pair goes out whole, so every letter here is a result and
        // the held output fills the block until it stalls the input.
        for (int k = 0; k < BURST_BYTES; k++) queue_req(OP_BYTE, 8'h61 + 8'(k));
        queue_req(OP_END, 8'h00);
      end
      placed = 0;
      while (placed < PHASE_ITEMS) begin
        if (text_q.size() == 0) build_string();
        while (text_q.size() != 0) begin
          r = text_q.pop_front();
          push_request(r.op, r.data, 1'b0, 1'b0, '0);
          placed++;
        end
      end
    end

    settle();
    $display("Sent %0d requests in %0d strings over %0d register writes.",
             requests_sent, strings_ended, cfg_writes);
    $display("Checked %0d results; %0d strings reported a selected field.",
             results_checked, found_count);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
